// ----- rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the sparse triple transpose core
// Field widths, queue command format, term record and bucket mapping.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int MAX_TERMS   = 64;
	localparam int MAX_DIM     = 64;
	// one bucket per column below MAX_DIM plus one overflow bucket
	localparam int NUM_BKT     = MAX_DIM + 1;

	localparam int IDX_W       = 7;
	localparam int VAL_W       = 32;
	localparam int FIELD_W     = 2 * IDX_W + VAL_W;
	localparam int DATA_W      = ((FIELD_W + 7) / 8) * 8;
	localparam int PAD_W       = DATA_W - FIELD_W;

	localparam int TERM_AW     = $clog2(MAX_TERMS);
	localparam int BKT_AW      = $clog2(NUM_BKT);
	localparam int BKT_CW      = $clog2(NUM_BKT + 1);
	localparam int CNT_W       = $clog2(MAX_TERMS + 1);

	// power of two, so the pointers wrap on their own width
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_HDR,
		CMD_TERM,
		CMD_TERM_LAST
	} cmd_kind_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] val;
	} term_t;

	typedef struct packed {
		cmd_kind_t kind;
		term_t     term;
	} cmd_t;

	// columns at or beyond MAX_DIM share the overflow bucket
	function automatic logic [BKT_AW-1:0] bucket_of(input logic [IDX_W-1:0] col);
		logic [BKT_AW-1:0] b;
		if (col < IDX_W'(MAX_DIM)) begin
			b = BKT_AW'(col);
		end else begin
			b = BKT_AW'(MAX_DIM);
		end
		return b;
	endfunction

endpackage

// ----- rtl/stt_ram.sv -----
// ----------------------------------------------------------------------------
// stt_ram: generic simple dual-port RAM
// One write port, one read port with registered data held while re is low.
// ----------------------------------------------------------------------------
module stt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/stt_front.sv -----
// ----------------------------------------------------------------------------
// stt_front: input side of the transpose core
// Accept items, saturate header counts, drop stray triples, tag the final one.
// ----------------------------------------------------------------------------
module stt_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [stt_pkg::DATA_W-1:0] s_axis_tdata,
	input  logic                       s_axis_tuser,
	input  logic                       q_full,
	output logic                       push,
	output stt_pkg::cmd_t              push_cmd
);

	logic [stt_pkg::IDX_W-1:0] row;
	logic [stt_pkg::IDX_W-1:0] col;
	logic [stt_pkg::VAL_W-1:0] val;
	logic [stt_pkg::CNT_W-1:0] cnt_sat;
	logic [stt_pkg::CNT_W-1:0] expected_q;
	logic [stt_pkg::CNT_W-1:0] received_q;
	logic                      acc;
	logic                      in_round;
	logic                      final_term;

	assign row = s_axis_tdata[stt_pkg::IDX_W-1:0];
	assign col = s_axis_tdata[2*stt_pkg::IDX_W-1:stt_pkg::IDX_W];
	assign val = s_axis_tdata[stt_pkg::FIELD_W-1:2*stt_pkg::IDX_W];

	assign s_axis_tready = !q_full;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign in_round      = received_q < expected_q;
	assign final_term    = (received_q + stt_pkg::CNT_W'(1)) == expected_q;

	always_comb begin
		if (val[stt_pkg::VAL_W-1]) begin
			cnt_sat = '0;
		end else if (val > stt_pkg::VAL_W'(stt_pkg::MAX_TERMS)) begin
			cnt_sat = stt_pkg::CNT_W'(stt_pkg::MAX_TERMS);
		end else begin
			cnt_sat = val[stt_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		push          = 1'b0;
		push_cmd.kind = stt_pkg::CMD_TERM;
		push_cmd.term = '{row: row, col: col, val: val};
		if (acc) begin
			if (s_axis_tuser) begin
				push              = 1'b1;
				push_cmd.kind     = stt_pkg::CMD_HDR;
				push_cmd.term.val = stt_pkg::VAL_W'(cnt_sat);
			end else if (in_round) begin
				push          = 1'b1;
				push_cmd.kind = final_term ? stt_pkg::CMD_TERM_LAST : stt_pkg::CMD_TERM;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			received_q <= '0;
		end else if (acc) begin
			if (s_axis_tuser) begin
				expected_q <= cnt_sat;
				received_q <= '0;
			end else if (in_round) begin
				if (final_term) begin
					expected_q <= '0;
					received_q <= '0;
				end else begin
					received_q <= received_q + stt_pkg::CNT_W'(1);
				end
			end
		end
	end

endmodule

// ----- rtl/stt_queue.sv -----
// ----------------------------------------------------------------------------
// stt_queue: short command queue between front and back
// Register-based FIFO of classified commands.
// ----------------------------------------------------------------------------
module stt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  stt_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output stt_pkg::cmd_t head
);

	stt_pkg::cmd_t              mem_q [stt_pkg::QUEUE_DEPTH];
	logic [stt_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [stt_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [stt_pkg::QCNT_W-1:0] count_q;
	logic                       do_push;
	logic                       do_pop;

	assign full       = count_q == stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + stt_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + stt_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + stt_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - stt_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/stt_back.sv -----
// ----------------------------------------------------------------------------
// stt_back: execution side of the transpose core
// Buffer triples, count columns, form start positions, scatter, emit.
// ----------------------------------------------------------------------------
module stt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  stt_pkg::cmd_t              q_head,
	output logic                       q_pop,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [stt_pkg::DATA_W-1:0] m_axis_tdata,
	output logic                       m_axis_tuser,
	output logic                       m_axis_tlast
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CNT_WR,
		ST_PREFIX,
		ST_SC_TERM,
		ST_SC_POS,
		ST_SC_WR,
		ST_EM_ORD,
		ST_EM_TERM,
		ST_EM_OUT
	} state_t;

	state_t                      state_q;
	logic [stt_pkg::CNT_W-1:0]   ld_cnt_q;
	logic [stt_pkg::BKT_AW-1:0]  bkt_q;
	logic                        last_q;
	logic [stt_pkg::BKT_CW-1:0]  pf_idx_q;
	logic                        pf_v_s1;
	logic [stt_pkg::BKT_AW-1:0]  pf_addr_s1;
	logic [stt_pkg::CNT_W-1:0]   pos_q;
	logic [stt_pkg::CNT_W-1:0]   sc_idx_q;
	logic [stt_pkg::CNT_W-1:0]   em_idx_q;
	logic [stt_pkg::NUM_BKT-1:0] cnt_vld_q;
	logic                        cnt_rvld_q;

	logic                        out_v_q;
	logic                        out_hdr_q;
	logic                        out_last_q;
	logic [stt_pkg::IDX_W-1:0]   out_row_q;
	logic [stt_pkg::IDX_W-1:0]   out_col_q;
	logic [stt_pkg::VAL_W-1:0]   out_val_q;

	logic                        t_we;
	logic [stt_pkg::TERM_AW-1:0] t_waddr;
	stt_pkg::term_t              t_wdata;
	logic                        t_re;
	logic [stt_pkg::TERM_AW-1:0] t_raddr;
	stt_pkg::term_t              t_rdata;

	logic                        c_we;
	logic [stt_pkg::BKT_AW-1:0]  c_waddr;
	logic [stt_pkg::CNT_W-1:0]   c_wdata;
	logic                        c_re;
	logic [stt_pkg::BKT_AW-1:0]  c_raddr;
	logic [stt_pkg::CNT_W-1:0]   c_rdata;

	logic                        o_we;
	logic [stt_pkg::TERM_AW-1:0] o_waddr;
	logic [stt_pkg::TERM_AW-1:0] o_wdata;
	logic                        o_re;
	logic [stt_pkg::TERM_AW-1:0] o_raddr;
	logic [stt_pkg::TERM_AW-1:0] o_rdata;

	logic [stt_pkg::CNT_W-1:0]   cnt_eff;
	logic                        out_free;
	logic                        out_load;
	logic                        pf_issue;
	logic                        sc_done;
	logic                        em_done;

	// buffered triples in arrival order
	stt_ram #(.WIDTH($bits(stt_pkg::term_t)), .DEPTH(stt_pkg::MAX_TERMS)) u_term_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// column counts, rewritten in place as running start positions
	stt_ram #(.WIDTH(stt_pkg::CNT_W), .DEPTH(stt_pkg::NUM_BKT)) u_cnt_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// output slot -> buffer index
	stt_ram #(.WIDTH(stt_pkg::TERM_AW), .DEPTH(stt_pkg::MAX_TERMS)) u_ord_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.re    (o_re),
		.raddr (o_raddr),
		.rdata (o_rdata)
	);

	// an entry not written since the last header reads as zero
	assign cnt_eff  = cnt_rvld_q ? c_rdata : '0;
	assign out_free = !out_v_q || m_axis_tready;
	assign pf_issue = pf_idx_q < stt_pkg::BKT_CW'(stt_pkg::NUM_BKT);
	assign sc_done  = (sc_idx_q + stt_pkg::CNT_W'(1)) == ld_cnt_q;
	assign em_done  = (em_idx_q + stt_pkg::CNT_W'(1)) == ld_cnt_q;

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_hdr_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{stt_pkg::PAD_W{1'b0}}, out_val_q, out_col_q, out_row_q};

	always_comb begin
		q_pop    = 1'b0;
		out_load = 1'b0;
		t_we     = 1'b0;
		t_waddr  = ld_cnt_q[stt_pkg::TERM_AW-1:0];
		t_wdata  = q_head.term;
		t_re     = 1'b0;
		t_raddr  = sc_idx_q[stt_pkg::TERM_AW-1:0];
		c_we     = 1'b0;
		c_waddr  = bkt_q;
		c_wdata  = cnt_eff + stt_pkg::CNT_W'(1);
		c_re     = 1'b0;
		c_raddr  = stt_pkg::bucket_of(q_head.term.col);
		o_we     = 1'b0;
		o_waddr  = cnt_eff[stt_pkg::TERM_AW-1:0];
		o_wdata  = sc_idx_q[stt_pkg::TERM_AW-1:0];
		o_re     = 1'b0;
		o_raddr  = em_idx_q[stt_pkg::TERM_AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_head.kind) inside
						stt_pkg::CMD_HDR: begin
							q_pop    = out_free;
							out_load = out_free;
						end
						stt_pkg::CMD_TERM, stt_pkg::CMD_TERM_LAST: begin
							q_pop = 1'b1;
							t_we  = 1'b1;
							c_re  = 1'b1;
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			ST_CNT_WR: begin
				c_we = 1'b1;
			end
			ST_PREFIX: begin
				c_re    = pf_issue;
				c_raddr = pf_idx_q[stt_pkg::BKT_AW-1:0];
				c_we    = pf_v_s1;
				c_waddr = pf_addr_s1;
				c_wdata = pos_q;
			end
			ST_SC_TERM: begin
				t_re = 1'b1;
			end
			ST_SC_POS: begin
				c_re    = 1'b1;
				c_raddr = stt_pkg::bucket_of(t_rdata.col);
			end
			ST_SC_WR: begin
				o_we = 1'b1;
				c_we = 1'b1;
			end
			ST_EM_ORD: begin
				o_re = 1'b1;
			end
			ST_EM_TERM: begin
				t_re    = 1'b1;
				t_raddr = o_rdata;
			end
			ST_EM_OUT: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ld_cnt_q   <= '0;
			bkt_q      <= '0;
			last_q     <= 1'b0;
			pf_idx_q   <= '0;
			pf_v_s1    <= 1'b0;
			pf_addr_s1 <= '0;
			pos_q      <= '0;
			sc_idx_q   <= '0;
			em_idx_q   <= '0;
			cnt_vld_q  <= '0;
			cnt_rvld_q <= 1'b0;
			out_v_q    <= 1'b0;
			out_hdr_q  <= 1'b0;
			out_last_q <= 1'b0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_val_q  <= '0;
		end else begin
			if (c_re) begin
				cnt_rvld_q <= cnt_vld_q[c_raddr];
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						unique case (q_head.kind) inside
							stt_pkg::CMD_HDR: begin
								if (out_free) begin
									out_hdr_q  <= 1'b1;
									out_row_q  <= q_head.term.col;
									out_col_q  <= q_head.term.row;
									out_val_q  <= q_head.term.val;
									out_last_q <= q_head.term.val == '0;
									cnt_vld_q  <= '0;
									ld_cnt_q   <= '0;
								end
							end
							stt_pkg::CMD_TERM, stt_pkg::CMD_TERM_LAST: begin
								bkt_q    <= stt_pkg::bucket_of(q_head.term.col);
								last_q   <= q_head.kind == stt_pkg::CMD_TERM_LAST;
								ld_cnt_q <= ld_cnt_q + stt_pkg::CNT_W'(1);
								state_q  <= ST_CNT_WR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CNT_WR: begin
					cnt_vld_q[bkt_q] <= 1'b1;
					if (last_q) begin
						pf_idx_q <= '0;
						pf_v_s1  <= 1'b0;
						pos_q    <= '0;
						state_q  <= ST_PREFIX;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PREFIX: begin
					pf_v_s1    <= pf_issue;
					pf_addr_s1 <= pf_idx_q[stt_pkg::BKT_AW-1:0];
					if (pf_issue) begin
						pf_idx_q <= pf_idx_q + stt_pkg::BKT_CW'(1);
					end
					if (pf_v_s1) begin
						pos_q                 <= pos_q + cnt_eff;
						cnt_vld_q[pf_addr_s1] <= 1'b1;
					end
					if (!pf_issue && !pf_v_s1) begin
						sc_idx_q <= '0;
						state_q  <= ST_SC_TERM;
					end
				end
				ST_SC_TERM: begin
					state_q <= ST_SC_POS;
				end
				ST_SC_POS: begin
					bkt_q   <= stt_pkg::bucket_of(t_rdata.col);
					state_q <= ST_SC_WR;
				end
				ST_SC_WR: begin
					sc_idx_q <= sc_idx_q + stt_pkg::CNT_W'(1);
					if (sc_done) begin
						em_idx_q <= '0;
						state_q  <= ST_EM_ORD;
					end else begin
						state_q <= ST_SC_TERM;
					end
				end
				ST_EM_ORD: begin
					state_q <= ST_EM_TERM;
				end
				ST_EM_TERM: begin
					state_q <= ST_EM_OUT;
				end
				ST_EM_OUT: begin
					if (out_free) begin
						out_hdr_q  <= 1'b0;
						out_row_q  <= t_rdata.col;
						out_col_q  <= t_rdata.row;
						out_val_q  <= t_rdata.val;
						out_last_q <= em_done;
						if (em_done) begin
							ld_cnt_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							em_idx_q <= em_idx_q + stt_pkg::CNT_W'(1);
							state_q  <= ST_EM_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/sparse_triple_transpose_core.sv -----
// ----------------------------------------------------------------------------
// sparse_triple_transpose_core: fast transpose of a sparse matrix in triples
// Stream in a header and its triples, stream out the transposed matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): a header transaction (tuser = 1) carries rows,
//   cols and the term count; the count is clamped to 0..64. Each following
//   triple (tuser = 0) is buffered until the announced count is reached;
//   triples outside a round are dropped. A header mid-round restarts.
//   Output stream (m_axis): the header comes back with rows and cols
//   swapped and the clamped count; then all triples follow sorted by column
//   (stable, columns of 64 and up last) with row and column swapped. tlast
//   marks the final transaction of the matrix, or an empty header.
//   Timing: a four-entry command queue decouples the input from the
//   sequencer. The sequencer loads each triple in the idle and count-write
//   states; after the final triple come a start-position pass over all 65
//   buckets, a scatter pass (term read, position read, write per triple)
//   and an emit pass (order read, term read, output per triple), all bound
//   by the single read port of each buffer RAM. A header result is loaded
//   from the queue head when the sequencer is idle and the output is free.
//   Reset: all control state clears at once; per-column valid bits make the
//   count store read as zero, so no clearing pass runs.
//   Stalls: a waiting result sits in the output register while the sequencer
//   keeps working until it needs that register; the input side stalls only
//   when the queue is full.
// ----------------------------------------------------------------------------
module sparse_triple_transpose_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// [6:0] row_index, [13:7] col_index, [45:14] term_value, [47:46] zero
	input  logic [stt_pkg::DATA_W-1:0] s_axis_tdata,
	// [0] is_header
	input  logic                       s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// [6:0] out_row, [13:7] out_col, [45:14] out_value, [47:46] zero
	output logic [stt_pkg::DATA_W-1:0] m_axis_tdata,
	// [0] out_is_header
	output logic                       m_axis_tuser,
	output logic                       m_axis_tlast
);

	logic          q_push;
	stt_pkg::cmd_t q_push_cmd;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	stt_pkg::cmd_t q_head;

	// classify and admit input transactions
	stt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (q_push),
		.push_cmd      (q_push_cmd)
	);

	// hold commands while the sequencer is busy
	stt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// buffer, count, sort and emit
	stt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// the front never writes a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	// the sequencer never pops an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command popped from empty queue");

	// a header result carries a clamped count
	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
		(m_axis_tdata[stt_pkg::FIELD_W-1:2*stt_pkg::IDX_W] <=
		 stt_pkg::VAL_W'(stt_pkg::MAX_TERMS)))
		else $error("header count above limit");

	// a header closes the matrix only when empty
	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser && m_axis_tlast) |->
		(m_axis_tdata[stt_pkg::FIELD_W-1:2*stt_pkg::IDX_W] == '0))
		else $error("nonempty header marked last");
`endif

endmodule
